/* rtl/sspq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by the interfaces, the cell and the top level.
package sspq_pkg;

   localparam int KEY_W    = 8;
   localparam int TAG_W    = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ENQUEUED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEQUEUED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd3;

   typedef struct packed {
      logic             enq;
      logic             deq;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } cell_cmd_type;

endpackage

/* rtl/sspq_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on sspq_pkg for field widths.
interface sspq_req_if import sspq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [TAG_W-1:0] entry_tag;
   logic [KEY_W-1:0] entry_key;

   modport source (output valid, req_type, entry_tag, entry_key, input ready);
   modport sink (input valid, req_type, entry_tag, entry_key, output ready);
endinterface

interface sspq_rsp_if import sspq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TAG_W-1:0]    out_tag;
   logic [KEY_W-1:0]    out_key;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, status, out_tag, out_key, occupancy, input ready);
   modport sink (input valid, status, out_tag, out_key, occupancy, output ready);
endinterface

/* rtl/sspq_cell.sv */
// One slot of the sorted chain: holds a key and tag, keeps, takes the new
// entry or shifts from a neighbour. Depends on sspq_pkg.
module sspq_cell import sspq_pkg::*; (
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic             occupied,
   input  logic [KEY_W-1:0] left_key,
   input  logic [TAG_W-1:0] left_tag,
   input  logic             left_keep,
   input  logic [KEY_W-1:0] right_key,
   input  logic [TAG_W-1:0] right_tag,
   output logic [KEY_W-1:0] key,
   output logic [TAG_W-1:0] tag,
   output logic             keep
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   assign keep = occupied && (key_ff >= cmd.key);

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (cmd.enq && !keep) begin
         if (left_keep) begin
            key_in = cmd.key;
            tag_in = cmd.tag;
         end else begin
            key_in = left_key;
            tag_in = left_tag;
         end
      end else if (cmd.deq) begin
         key_in = right_key;
         tag_in = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key = key_ff;
   assign tag = tag_ff;

endmodule

/* rtl/stable_sorted_priority_queue_unit.sv */
// Sorted priority queue built as a chain of key/tag cells.
// Depends on sspq_pkg, sspq_req_if, sspq_rsp_if and sspq_cell.
//
// Usage: a request item on req_ch either enqueues (entry_tag, entry_key) or
// dequeues the head. The largest key sits at the head; equal keys leave in
// arrival order. Each request yields exactly one response item on rsp_ch with
// a status (enqueued, dequeued, underflow, overflow), the removed tag and key
// (zero unless dequeued) and the occupancy after the request, modulo 32.
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one request per cycle while not stalled; every cell compares its
// key with the new key and shifts in parallel.
// Stall: the response register holds while rsp_ch.ready is low; a new request
// is taken only when that register is empty or being drained.
// Reset (synchronous, active high) empties the queue and drops any pending
// response; cell contents are not cleared.
module stable_sorted_priority_queue_unit import sspq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   sspq_req_if.sink   req_ch,
   sspq_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TAG_W-1:0]    out_tag_ff, out_tag_in;
   logic [KEY_W-1:0]    out_key_ff, out_key_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;

   logic         accept, full, empty;
   cell_cmd_type cmd;

   logic [KEY_W-1:0] cell_key  [QUEUE_DEPTH];
   logic [TAG_W-1:0] cell_tag  [QUEUE_DEPTH];
   logic             cell_keep [QUEUE_DEPTH];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty        = (count_ff == '0);

   assign cmd.enq = accept && (req_ch.req_type == REQ_ENQUEUE) && !full;
   assign cmd.deq = accept && (req_ch.req_type == REQ_DEQUEUE) && !empty;
   assign cmd.key = req_ch.entry_key;
   assign cmd.tag = req_ch.entry_tag;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0] lk, rk;
      logic [TAG_W-1:0] lt, rt;
      logic             lkeep;

      if (i == 0) begin : g_head
         assign lk    = cmd.key;
         assign lt    = cmd.tag;
         assign lkeep = 1'b1;
      end else begin : g_body
         assign lk    = cell_key[i-1];
         assign lt    = cell_tag[i-1];
         assign lkeep = cell_keep[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign rk = cell_key[i];
         assign rt = cell_tag[i];
      end else begin : g_inner
         assign rk = cell_key[i+1];
         assign rt = cell_tag[i+1];
      end

      sspq_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (CNT_W'(i) < count_ff),
         .left_key  (lk),
         .left_tag  (lt),
         .left_keep (lkeep),
         .right_key (rk),
         .right_tag (rt),
         .key       (cell_key[i]),
         .tag       (cell_tag[i]),
         .keep      (cell_keep[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      out_tag_in   = out_tag_ff;
      out_key_in   = out_key_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_tag_in   = '0;
         out_key_in   = '0;
         if (req_ch.req_type == REQ_DEQUEUE) begin
            if (empty) begin
               status_in = STATUS_UNDERFLOW;
            end else begin
               status_in  = STATUS_DEQUEUED;
               out_tag_in = cell_tag[0];
               out_key_in = cell_key[0];
               count_in   = count_ff - CNT_W'(1);
            end
         end else begin
            if (full) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               status_in = STATUS_ENQUEUED;
               count_in  = count_ff + CNT_W'(1);
            end
         end
      end
      occ_in = accept ? OCC_W'(count_in) : occ_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      out_tag_ff <= out_tag_in;
      out_key_ff <= out_key_in;
      occ_ff     <= occ_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.out_tag   = out_tag_ff;
   assign rsp_ch.out_key   = out_key_ff;
   assign rsp_ch.occupancy = occ_ff;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for stable_sorted_priority_queue_unit: a shadow sorted
// queue predicts each response item, a clocked driver and monitor run the channels.
// Depends on sspq_pkg, sspq_req_if, sspq_rsp_if and the unit itself.
`timescale 1ns / 100ps

module tb_top;
   import sspq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BULK = 1500;
   localparam int RANDOM_TAIL = 200;
   localparam logic [KEY_W-1:0] TIE_KEYS [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

   typedef struct packed {
      logic             kind;
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } request_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    tag;
      logic [KEY_W-1:0]    key;
      logic [OCC_W-1:0]    occ;
   } response_t;

   logic clock;
   logic reset;

   sspq_req_if req_ch();
   sspq_rsp_if rsp_ch();

   stable_sorted_priority_queue_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   request_t  pending_requests[$];
   response_t due_responses[$];

   logic [KEY_W-1:0] held_key [QUEUE_DEPTH];
   logic [TAG_W-1:0] held_tag [QUEUE_DEPTH];
   int               held_count;

   int  send_gap;
   int  stall_left;
   int  mismatches;
   int  cycles;
   bit  quiet;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_ENQUEUE;
      req_ch.entry_tag = '0;
      req_ch.entry_key = '0;
      rsp_ch.ready = 1'b0;
   end

   always #2 clock = ~clock;

   // shadow queue: sorted, largest key first, ties behind earlier entries
   function automatic response_t apply_request(request_t rq);
      response_t r;
      int        pos;
      int        i;
      r = '{status: STATUS_ENQUEUED, tag: '0, key: '0, occ: '0};
      if (rq.kind == REQ_DEQUEUE) begin
         if (held_count == 0) begin
            r.status = STATUS_UNDERFLOW;
         end else begin
            r.status = STATUS_DEQUEUED;
            r.tag = held_tag[0];
            r.key = held_key[0];
            for (i = 1; i < held_count; i++) begin
               held_key[i-1] = held_key[i];
               held_tag[i-1] = held_tag[i];
            end
            held_count--;
         end
      end else if (held_count >= QUEUE_DEPTH) begin
         r.status = STATUS_OVERFLOW;
      end else begin
         pos = 0;
         while (pos < held_count && held_key[pos] >= rq.key)
            pos++;
         for (i = held_count; i > pos; i--) begin
            held_key[i] = held_key[i-1];
            held_tag[i] = held_tag[i-1];
         end
         held_key[pos] = rq.key;
         held_tag[pos] = rq.tag;
         held_count++;
      end
      r.occ = held_count[OCC_W-1:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            request_t rq;
            rq = pending_requests.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.req_type <= rq.kind;
            req_ch.entry_tag <= rq.tag;
            req_ch.entry_key <= rq.key;
            if (!quiet && $urandom_range(0, 9) == 0)
               send_gap <= $urandom_range(1, 17);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // predict on every accepted request item
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         due_responses.push_back(apply_request('{kind: req_ch.req_type,
                                                 tag: req_ch.entry_tag,
                                                 key: req_ch.entry_key}));
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_responses.size() == 0) begin
            $error("unexpected response item: status %0d", rsp_ch.status);
            mismatches++;
         end else begin
            response_t exp_r;
            exp_r = due_responses.pop_front();
            if (rsp_ch.status !== exp_r.status) begin
               $error("status: expected %0d, actual %0d", exp_r.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.out_tag !== exp_r.tag) begin
               $error("out_tag: expected %0h, actual %0h", exp_r.tag, rsp_ch.out_tag);
               mismatches++;
            end
            if (rsp_ch.out_key !== exp_r.key) begin
               $error("out_key: expected %0h, actual %0h", exp_r.key, rsp_ch.out_key);
               mismatches++;
            end
            if (rsp_ch.occupancy !== exp_r.occ) begin
               $error("occupancy: expected %0d, actual %0d", exp_r.occ, rsp_ch.occupancy);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic add_request(logic kind, logic [TAG_W-1:0] tag, logic [KEY_W-1:0] key);
      pending_requests.push_back('{kind: kind, tag: tag, key: key});
   endtask

   // runs of traffic with a random enqueue share of 10 to 90 percent; keys often repeat to force ties
   task automatic add_random(int count);
      int               left;
      int               run;
      int               enq_pct;
      logic [KEY_W-1:0] key;
      left = count;
      while (left > 0) begin
         run = $urandom_range(8, 48);
         enq_pct = $urandom_range(10, 90);
         while (run > 0 && left > 0) begin
            if ($urandom_range(0, 1))
               key = TIE_KEYS[$urandom_range(0, 5)];
            else
               key = KEY_W'($urandom_range(0, 255));
            add_request(($urandom_range(1, 100) <= enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE,
                        TAG_W'($urandom_range(0, 16'hffff)), key);
            run--;
            left--;
         end
      end
   endtask

   // sample on the falling edge so that the driver and monitor updates have settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() > 0 || req_ch.valid || due_responses.size() > 0)
         @(negedge clock);
   endtask

   initial begin
      held_count = 0;
      mismatches = 0;
      cycles = 0;
      quiet = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // underflow, fill with ties and extremes, overflow, then drain part way
      add_request(REQ_DEQUEUE, 16'hffff, 8'hff);
      add_request(REQ_ENQUEUE, 16'h0000, 8'd0);
      add_request(REQ_ENQUEUE, 16'hffff, 8'd255);
      add_request(REQ_ENQUEUE, 16'h0001, 8'd128);
      add_request(REQ_ENQUEUE, 16'h0002, 8'd128);
      add_request(REQ_ENQUEUE, 16'h0003, 8'd128);
      add_request(REQ_ENQUEUE, 16'h0004, 8'd0);
      add_request(REQ_ENQUEUE, 16'h0005, 8'd255);
      add_request(REQ_ENQUEUE, 16'haaaa, 8'd1);
      add_request(REQ_ENQUEUE, 16'h5555, 8'd254);
      add_request(REQ_ENQUEUE, 16'h0006, 8'd127);
      add_request(REQ_ENQUEUE, 16'h0007, 8'd129);
      add_request(REQ_ENQUEUE, 16'h0008, 8'd128);
      add_request(REQ_ENQUEUE, 16'h8000, 8'h80);
      add_request(REQ_ENQUEUE, 16'h0009, 8'h55);
      add_request(REQ_ENQUEUE, 16'h000a, 8'haa);
      add_request(REQ_ENQUEUE, 16'h000b, 8'd255);
      add_request(REQ_ENQUEUE, 16'hbeef, 8'd255);
      for (int i = 0; i < 6; i++)
         add_request(REQ_DEQUEUE, 16'h0000, 8'd0);

      // hold the sender until every response item is back
      wait_drained();

      add_random(RANDOM_BULK);
      while (pending_requests.size() > 0)
         @(posedge clock);
      quiet = 1'b1;
      add_random(RANDOM_TAIL);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
